FILE: src/imhos_pkg.sv
package imhos_pkg;

    // node ids, parents and cost keys as they travel on the ports
    localparam int NODE_BITS = 12;
    localparam int COST_BITS = 32;
    localparam int NODE_SPAN = 4096;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_INHEAP = 2'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [NODE_BITS-1:0] node_id;
        logic [NODE_BITS-1:0] parent_id;
        logic [COST_BITS-1:0] key_cost;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [NODE_BITS-1:0] out_node;
        logic [COST_BITS-1:0] out_cost;
        logic [NODE_BITS-1:0] out_parent;
        logic                 was_visited;
        logic                 in_heap;
        logic                 heap_empty;
    } t_res;

    // per-field write enables of the node table
    typedef struct packed {
        logic parent;
        logic visited;
        logic open;
    } t_node_we;

endpackage

FILE: src/imhos_heap_mem.sv
module imhos_heap_mem #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12,
    parameter int KW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [IW-1:0] i_wnode,
    input  logic [KW-1:0] i_wkey,
    input  logic [IW-1:0] i_raddr,
    output logic [IW-1:0] o_rnode,
    output logic [KW-1:0] o_rkey
);

    logic [IW-1:0] mem_node [DEPTH];
    logic [KW-1:0] mem_key  [DEPTH];

    // heap slots: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_node[i_waddr] <= i_wnode;
            mem_key[i_waddr]  <= i_wkey;
        end
        o_rnode <= mem_node[i_raddr];
        o_rkey  <= mem_key[i_raddr];
    end

endmodule

FILE: src/imhos_node_mem.sv
module imhos_node_mem #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12
) (
    input  logic                            i_clk,
    input  imhos_pkg::t_node_we             i_we,
    input  logic [IW-1:0]                   i_waddr,
    input  logic [imhos_pkg::NODE_BITS-1:0] i_wparent,
    input  logic                            i_wvisited,
    input  logic                            i_wopen,
    input  logic [IW-1:0]                   i_raddr,
    output logic [imhos_pkg::NODE_BITS-1:0] o_rparent,
    output logic                            o_rvisited,
    output logic                            o_ropen
);

    import imhos_pkg::*;

    logic [NODE_BITS-1:0] mem_parent  [DEPTH];
    logic                 mem_visited [DEPTH];
    logic                 mem_open    [DEPTH];

    // node table with per-field writes and a registered read
    always_ff @(posedge i_clk) begin
        if (i_we.parent) begin
            mem_parent[i_waddr] <= i_wparent;
        end
        if (i_we.visited) begin
            mem_visited[i_waddr] <= i_wvisited;
        end
        if (i_we.open) begin
            mem_open[i_waddr] <= i_wopen;
        end
        o_rparent  <= mem_parent[i_raddr];
        o_rvisited <= mem_visited[i_raddr];
        o_ropen    <= mem_open[i_raddr];
    end

endmodule

FILE: src/indexed_min_heap_open_set_unit.sv
// Indexed binary min-heap for the open set of a grid search. A request is taken when start
// is high and busy is low; its single result appears on o_res for one cycle with o_done
// and must be captured then. After reset the block sweeps the visited/open marks of all
// NODE_COUNT nodes with busy high. An insert climbs and a pop descends the heap one level
// at a time; each level costs a registered read of the heap memory, and a NODE_COUNT
// below 4096 adds restoring steps of node id reduction to every request.
module indexed_min_heap_open_set_unit #(
    parameter int NODE_COUNT = 4096,
    parameter int KEY_WIDTH  = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  imhos_pkg::t_req i_req,
    output logic            busy,
    output logic            o_done,
    output imhos_pkg::t_res o_res
);

    import imhos_pkg::*;

    function automatic int red_steps(int n);
        int s;
        s = 0;
        for (int i = 0; i < NODE_BITS; i++) begin
            if ((n << s) < NODE_SPAN) s++;
        end
        return s;
    endfunction

    localparam int IW        = $clog2(NODE_COUNT);
    localparam int CW        = $clog2(NODE_COUNT + 1);
    localparam int RED_STEPS = red_steps(NODE_COUNT);
    localparam int RKW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RED, S_DISP, S_INS_CHK, S_UP, S_UP_CMP,
        S_QRY, S_POP_A, S_POP_B, S_DOWN, S_DOWN_L, S_DOWN_R
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_clr, n_clr;
    logic [1:0]           r_type, n_type;
    logic [NODE_BITS-1:0] r_red, n_red;
    logic [RKW-1:0]       r_k, n_k;
    logic [NODE_BITS-1:0] r_parent, n_parent;
    logic [IW-1:0]        r_pos, n_pos;
    logic [IW-1:0]        r_up, n_up;
    logic [IW-1:0]        r_cur_node, n_cur_node;
    logic [KEY_WIDTH-1:0] r_cur_key, n_cur_key;
    logic [IW-1:0]        r_top, n_top;
    logic [IW-1:0]        r_l_node, n_l_node;
    logic [KEY_WIDTH-1:0] r_l_key, n_l_key;
    logic                 r_done, n_done;
    t_res                 r_res, n_res;

    // memory ports
    logic                 h_we;
    logic [IW-1:0]        h_waddr, h_wnode, h_raddr, h_rnode;
    logic [KEY_WIDTH-1:0] h_wkey, h_rkey;
    t_node_we             t_we;
    logic [IW-1:0]        t_waddr, t_raddr;
    logic [NODE_BITS-1:0] t_wparent, t_rparent;
    logic                 t_wvisited, t_wopen, t_rvisited, t_ropen;

    // derived positions
    logic [IW:0]          left, right;
    logic [31:0]          red_sub;
    logic [IW-1:0]        idx;
    logic                 pick_r;

    imhos_heap_mem #(.DEPTH(NODE_COUNT), .IW(IW), .KW(KEY_WIDTH)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wnode (h_wnode),
        .i_wkey  (h_wkey),
        .i_raddr (h_raddr),
        .o_rnode (h_rnode),
        .o_rkey  (h_rkey)
    );

    imhos_node_mem #(.DEPTH(NODE_COUNT), .IW(IW)) u_nodes (
        .i_clk      (i_clk),
        .i_we       (t_we),
        .i_waddr    (t_waddr),
        .i_wparent  (t_wparent),
        .i_wvisited (t_wvisited),
        .i_wopen    (t_wopen),
        .i_raddr    (t_raddr),
        .o_rparent  (t_rparent),
        .o_rvisited (t_rvisited),
        .o_ropen    (t_ropen)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    assign left    = {r_pos, 1'b1};
    assign right   = left + (IW+1)'(1);
    assign red_sub = 32'(NODE_COUNT) << r_k;
    assign idx     = IW'(r_red);
    assign pick_r  = (h_rkey < r_l_key);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_clr      = r_clr;
        n_type     = r_type;
        n_red      = r_red;
        n_k        = r_k;
        n_parent   = r_parent;
        n_pos      = r_pos;
        n_up       = r_up;
        n_cur_node = r_cur_node;
        n_cur_key  = r_cur_key;
        n_top      = r_top;
        n_l_node   = r_l_node;
        n_l_key    = r_l_key;
        n_done     = 1'b0;
        n_res      = r_res;

        h_we       = 1'b0;
        h_waddr    = r_pos;
        h_wnode    = r_cur_node;
        h_wkey     = r_cur_key;
        h_raddr    = '0;
        t_we       = '0;
        t_waddr    = idx;
        t_wparent  = r_parent;
        t_wvisited = 1'b1;
        t_wopen    = 1'b1;
        t_raddr    = idx;

        case (r_state)
            // sweep the marks after reset
            S_CLEAR: begin
                t_we       = '{parent: 1'b0, visited: 1'b1, open: 1'b1};
                t_waddr    = r_clr;
                t_wvisited = 1'b0;
                t_wopen    = 1'b0;
                n_clr      = r_clr + IW'(1);
                if (r_clr == IW'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // request transfer
            S_IDLE: begin
                if (start) begin
                    n_type    = i_req.req_type;
                    n_red     = i_req.node_id;
                    n_parent  = i_req.parent_id;
                    n_cur_key = KEY_WIDTH'(i_req.key_cost);
                    n_k       = RKW'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
                    n_state   = (RED_STEPS > 0) ? S_RED : S_DISP;
                end
            end

            // node id modulo node count, one restoring step per cycle
            S_RED: begin
                if (32'(r_red) >= red_sub) begin
                    n_red = r_red - NODE_BITS'(red_sub);
                end
                if (r_k == '0) begin
                    n_state = S_DISP;
                end else begin
                    n_k = r_k - RKW'(1);
                end
            end

            S_DISP: begin
                n_res.out_node   = NODE_BITS'(idx);
                n_res.out_cost   = '0;
                n_res.out_parent = '0;
                n_res.status     = ST_OK;
                case (r_type)
                    REQ_INSERT: begin
                        n_cur_node = idx;
                        n_state    = S_INS_CHK;
                    end
                    REQ_POP: begin
                        if (r_count == '0) begin
                            n_res.status      = ST_EMPTY;
                            n_res.out_node    = '0;
                            n_res.was_visited = 1'b0;
                            n_res.in_heap     = 1'b0;
                            n_res.heap_empty  = 1'b1;
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            h_raddr = '0;
                            n_state = S_POP_A;
                        end
                    end
                    default: begin
                        n_state = S_QRY;
                    end
                endcase
            end

            S_QRY: begin
                n_res.was_visited = t_rvisited;
                n_res.in_heap     = t_ropen;
                n_res.out_parent  = t_rvisited ? t_rparent : '0;
                n_res.heap_empty  = (r_count == '0);
                n_done            = 1'b1;
                n_state           = S_IDLE;
            end

            // insert checks, then place the new entry at the end
            S_INS_CHK: begin
                n_res.was_visited = t_rvisited;
                n_res.in_heap     = t_ropen;
                n_res.heap_empty  = (r_count == '0);
                if (r_count >= CW'(NODE_COUNT)) begin
                    n_res.status = ST_FULL;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else if (t_ropen) begin
                    n_res.status = ST_INHEAP;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    t_we              = '{parent: 1'b1, visited: 1'b1, open: 1'b1};
                    t_waddr           = r_cur_node;
                    n_res.was_visited = 1'b1;
                    n_res.in_heap     = 1'b1;
                    n_res.heap_empty  = 1'b0;
                    n_pos             = IW'(r_count);
                    n_count           = r_count + CW'(1);
                    n_state           = S_UP;
                end
            end

            // sift up: the new entry rides in registers, parents move down
            S_UP: begin
                if (r_pos == '0) begin
                    h_we    = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_up    = (r_pos - IW'(1)) >> 1;
                    h_raddr = (r_pos - IW'(1)) >> 1;
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                h_we = 1'b1;
                if (r_cur_key > h_rkey) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    h_wnode = h_rnode;
                    h_wkey  = h_rkey;
                    n_pos   = r_up;
                    n_state = S_UP;
                end
            end

            // pop: take the root, fetch the last entry and the root's parent
            S_POP_A: begin
                n_top             = h_rnode;
                n_res.out_node    = NODE_BITS'(h_rnode);
                n_res.out_cost    = COST_BITS'(h_rkey);
                t_raddr           = h_rnode;
                h_raddr           = IW'(r_count - CW'(1));
                n_state           = S_POP_B;
            end

            S_POP_B: begin
                n_res.out_parent  = t_rparent;
                n_res.was_visited = 1'b1;
                n_res.in_heap     = 1'b0;
                n_res.heap_empty  = (r_count == CW'(1));
                t_we              = '{parent: 1'b0, visited: 1'b0, open: 1'b1};
                t_waddr           = r_top;
                t_wopen           = 1'b0;
                n_cur_node        = h_rnode;
                n_cur_key         = h_rkey;
                n_pos             = '0;
                n_count           = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DOWN;
                end
            end

            // sift down: the moved entry rides in registers, smaller children move up
            S_DOWN: begin
                if (left >= (IW+1)'(r_count)) begin
                    h_we    = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    h_raddr = left[IW-1:0];
                    n_state = S_DOWN_L;
                end
            end

            S_DOWN_L: begin
                n_l_node = h_rnode;
                n_l_key  = h_rkey;
                if (right < (IW+1)'(r_count)) begin
                    h_raddr = right[IW-1:0];
                    n_state = S_DOWN_R;
                end else begin
                    h_we = 1'b1;
                    if (h_rkey < r_cur_key) begin
                        h_wnode = h_rnode;
                        h_wkey  = h_rkey;
                        n_pos   = left[IW-1:0];
                        n_state = S_DOWN;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            S_DOWN_R: begin
                h_we = 1'b1;
                if (pick_r && (h_rkey < r_cur_key)) begin
                    h_wnode = h_rnode;
                    h_wkey  = h_rkey;
                    n_pos   = right[IW-1:0];
                    n_state = S_DOWN;
                end else if (!pick_r && (r_l_key < r_cur_key)) begin
                    h_wnode = r_l_node;
                    h_wkey  = r_l_key;
                    n_pos   = left[IW-1:0];
                    n_state = S_DOWN;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_type     <= n_type;
        r_red      <= n_red;
        r_k        <= n_k;
        r_parent   <= n_parent;
        r_pos      <= n_pos;
        r_up       <= n_up;
        r_cur_node <= n_cur_node;
        r_cur_key  <= n_cur_key;
        r_top      <= n_top;
        r_l_node   <= n_l_node;
        r_l_key    <= n_l_key;
        r_res      <= n_res;
    end

endmodule
